[design/rpd_pkg.sv]
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared constants, codes and controller/datapath interface types for the
// row predictor and planar run-length image decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

  localparam int MaxRowPixelsDef = 1024;
  localparam int MaxChannelsDef  = 4;

  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BPP    = 2'd2;

  // decoder phases
  localparam logic [2:0] PH_FILTER    = 3'd0;
  localparam logic [2:0] PH_PREDICT   = 3'd1;
  localparam logic [2:0] PH_LITERAL   = 3'd2;
  localparam logic [2:0] PH_AFTER     = 3'd3;
  localparam logic [2:0] PH_COUNT     = 3'd4;
  localparam logic [2:0] PH_AFTER_END = 3'd5;
  localparam logic [2:0] PH_COUNT_END = 3'd6;

  // filter codes
  localparam logic [2:0] FILT_LEFT    = 3'd0;
  localparam logic [2:0] FILT_UP      = 3'd1;
  localparam logic [2:0] FILT_UPLEFT  = 3'd2;
  localparam logic [2:0] FILT_UPRIGHT = 3'd3;
  localparam logic [7:0] FILT_LAST    = 8'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_CLIPPED = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
    logic run_step;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic run_pending;
    logic run_last;
    logic clear_pending;
    logic clear_last;
  } sts_t;

endpackage

`default_nettype wire

[design/rpd_ram.sv]
// ----------------------------------------------------------------------------
// rpd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/rpd_ctrl.sv]
// ----------------------------------------------------------------------------
// rpd_ctrl
// Sequencer: takes one byte, reads the line store, executes the decode step,
// then runs run-length fills or the line store clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rpd_pkg::sts_t sts,
  output rpd_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE) || !rst_n;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec = 1'b1;
          if (sts.run_pending) state_nxt = S_RUN;
          else if (sts.clear_pending) state_nxt = S_CLEAR;
          else state_nxt = S_IDLE;
        end
      end
      S_RUN: begin
        cmd.run_step = 1'b1;
        if (sts.run_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[design/rpd_dp.sv]
// ----------------------------------------------------------------------------
// rpd_dp
// Datapath: configuration, decoder state, prediction and run arithmetic,
// line store and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_dp #(
  parameter int MAX_ROW_PIXELS = rpd_pkg::MaxRowPixelsDef,
  parameter int MAX_CHANNELS   = rpd_pkg::MaxChannelsDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [rpd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [rpd_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic [7:0]                   in_data_byte,
  input  wire logic                         in_frame_start,
  input  wire rpd_pkg::cmd_t                cmd,
  output rpd_pkg::sts_t                     sts,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [15:0]                       out_row_index,
  output logic [9:0]                        out_column,
  output logic [1:0]                        out_channel,
  output logic [7:0]                        out_pixel_value,
  output logic [8:0]                        out_run_length,
  output logic                              out_row_done,
  output logic [1:0]                        out_status
);

  localparam int Depth = MAX_ROW_PIXELS * MAX_CHANNELS;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(MAX_ROW_PIXELS) + 1;

  // configuration
  logic [10:0] cfg_w_r;
  logic [15:0] cfg_h_r;
  logic [2:0]  cfg_b_r;

  // decoder state
  logic [7:0]    d_r;
  logic          fs_r;
  logic [2:0]    mode_r, mode_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [1:0]    ch_r, ch_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [2:0]    ph_r, ph_nxt;
  logic [7:0]    lit_r, lit_nxt;
  logic [31:0]   left_r, left_nxt;
  logic [31:0]   hold_r, hold_nxt;

  // run fill and clearing pass
  logic [8:0]    run_cnt_r;
  logic [CW-1:0] run_col_r;
  logic [1:0]    run_ch_r;
  logic [AW-1:0] clr_addr_r;
  logic          out_valid_r;

  logic [CW-1:0] eff_w;
  logic [15:0]   eff_h;
  logic [2:0]    eff_b;

  // step results
  logic          e_emit;
  logic [15:0]   e_row;
  logic [CW-1:0] e_col;
  logic [1:0]    e_ch;
  logic [7:0]    e_val;
  logic [8:0]    e_run;
  logic          e_done;
  logic [1:0]    e_st;
  logic          x_we;
  logic [7:0]    x_wdata;
  logic [8:0]    run_n;
  logic          do_lit, do_filt;
  logic [2:0]    ch_inc;
  logic [CW:0]   col_inc;
  logic [CW-1:0] rem;
  logic [7:0]    rd_byte, v;

  // line store ports
  logic          rok_r;
  logic [CW:0]   rcol;
  logic          rok;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          wok;
  logic [AW-1:0] waddr_x, waddr_run, mem_waddr;
  logic          mem_we;
  logic [7:0]    mem_wdata;

  always_comb begin
    if (cfg_w_r == 11'd0) eff_w = CW'(1);
    else if (int'(cfg_w_r) > MAX_ROW_PIXELS) eff_w = CW'(MAX_ROW_PIXELS);
    else eff_w = CW'(cfg_w_r);
    eff_h = (cfg_h_r == 16'd0) ? 16'd1 : cfg_h_r;
    if (cfg_b_r < 3'd3) eff_b = 3'd3;
    else if (int'(cfg_b_r) > MAX_CHANNELS) eff_b = 3'(MAX_CHANNELS);
    else eff_b = cfg_b_r;
  end

  // read address: up-right reads the next column, others the current one
  assign rcol  = (mode_r == rpd_pkg::FILT_UPRIGHT) ? ({1'b0, col_r} + 1'b1) : {1'b0, col_r};
  assign rok   = (int'(rcol) < MAX_ROW_PIXELS) && (int'(ch_r) < MAX_CHANNELS);
  assign raddr = AW'(int'(rcol) * MAX_CHANNELS + int'(ch_r));
  assign rd_byte = rok_r ? rdata : 8'd0;

  assign wok     = (int'(col_r) < MAX_ROW_PIXELS) && (int'(ch_r) < MAX_CHANNELS);
  assign waddr_x = AW'(int'(col_r) * MAX_CHANNELS + int'(ch_r));
  assign waddr_run = AW'(int'(run_col_r) * MAX_CHANNELS + int'(run_ch_r));

  always_comb begin
    mode_nxt = mode_r; col_nxt = col_r; ch_nxt = ch_r; row_nxt = row_r;
    ph_nxt = ph_r; lit_nxt = lit_r; left_nxt = left_r; hold_nxt = hold_r;
    e_emit = 1'b0; e_row = row_r; e_col = '0; e_ch = 2'd0; e_val = 8'd0;
    e_run = 9'd0; e_done = 1'b0; e_st = rpd_pkg::ST_OK;
    x_we = 1'b0; x_wdata = 8'd0; run_n = 9'd0;
    do_lit = 1'b0; do_filt = 1'b0; v = d_r;
    ch_inc = {1'b0, ch_r} + 3'd1;
    col_inc = {1'b0, col_r} + 1'b1;
    rem = (col_r < eff_w) ? (eff_w - col_r) : '0;
    if (!fs_r && row_r >= eff_h) begin
      e_emit = 1'b1;
      e_st   = rpd_pkg::ST_DONE;
    end else begin
      case (ph_r)
        rpd_pkg::PH_PREDICT: begin
          case (mode_r)
            rpd_pkg::FILT_LEFT: if (col_r != '0) v = d_r + left_r[8*ch_r +: 8];
            rpd_pkg::FILT_UP: v = d_r + rd_byte;
            rpd_pkg::FILT_UPLEFT: if (col_r != '0) v = d_r + hold_r[8*ch_r +: 8];
            default: if (col_inc < {1'b0, eff_w}) v = d_r + rd_byte;
          endcase
          x_we = wok;
          x_wdata = v;
          left_nxt[8*ch_r +: 8] = v;
          hold_nxt[8*ch_r +: 8] = rd_byte;
          if (ch_inc >= eff_b) begin
            ch_nxt  = 2'd0;
            col_nxt = col_inc[CW-1:0];
          end else begin
            ch_nxt = ch_inc[1:0];
          end
          e_emit = 1'b1; e_col = col_r; e_ch = ch_r; e_val = v; e_run = 9'd1;
          if (((ch_inc >= eff_b) ? col_inc : {1'b0, col_r}) >= {1'b0, eff_w}) begin
            e_done = 1'b1;
            row_nxt = (row_r < 16'hFFFF) ? row_r + 16'd1 : row_r;
            col_nxt = '0;
            ch_nxt  = 2'd0;
            ph_nxt  = rpd_pkg::PH_FILTER;
          end
        end
        rpd_pkg::PH_LITERAL: do_lit = 1'b1;
        rpd_pkg::PH_AFTER: begin
          if (d_r == lit_r) ph_nxt = rpd_pkg::PH_COUNT;
          else do_lit = 1'b1;
        end
        rpd_pkg::PH_COUNT: begin
          run_n = (int'(d_r) < int'(rem)) ? {1'b0, d_r} : 9'(rem);
          e_emit = 1'b1; e_col = col_r; e_ch = ch_r; e_val = lit_r; e_run = run_n;
          e_st = (int'(d_r) > int'(rem)) ? rpd_pkg::ST_CLIPPED : rpd_pkg::ST_OK;
          col_nxt = CW'({1'b0, col_r} + (CW+1)'(run_n));
          ph_nxt = rpd_pkg::PH_LITERAL;
          if (({1'b0, col_r} + (CW+1)'(run_n)) >= {1'b0, eff_w}) begin
            col_nxt = '0;
            if (ch_inc >= eff_b) begin
              e_done  = 1'b1;
              row_nxt = (row_r < 16'hFFFF) ? row_r + 16'd1 : row_r;
              ch_nxt  = 2'd0;
              ph_nxt  = rpd_pkg::PH_FILTER;
            end else begin
              ch_nxt = ch_inc[1:0];
            end
          end
        end
        rpd_pkg::PH_AFTER_END: begin
          if (d_r == lit_r) ph_nxt = rpd_pkg::PH_COUNT_END;
          else if (ch_r == 2'd0) do_filt = 1'b1;
          else do_lit = 1'b1;
        end
        rpd_pkg::PH_COUNT_END: begin
          e_emit = 1'b1; e_val = lit_r;
          e_st = (d_r != 8'd0) ? rpd_pkg::ST_CLIPPED : rpd_pkg::ST_OK;
          if (ch_r == 2'd0) begin
            e_row  = (row_r > 16'd0) ? row_r - 16'd1 : 16'd0;
            e_ch   = 2'(eff_b - 3'd1);
            ph_nxt = rpd_pkg::PH_FILTER;
          end else begin
            e_ch   = ch_r - 2'd1;
            ph_nxt = rpd_pkg::PH_LITERAL;
          end
        end
        default: do_filt = 1'b1;
      endcase
      if (do_filt) begin
        col_nxt = '0;
        ch_nxt  = 2'd0;
        if (d_r > rpd_pkg::FILT_LAST) begin
          e_emit = 1'b1; e_done = 1'b1; e_st = rpd_pkg::ST_UNKNOWN;
          row_nxt = (row_r < 16'hFFFF) ? row_r + 16'd1 : row_r;
          ph_nxt = rpd_pkg::PH_FILTER;
        end else begin
          mode_nxt = d_r[2:0];
          ph_nxt = (d_r == rpd_pkg::FILT_LAST) ? rpd_pkg::PH_LITERAL : rpd_pkg::PH_PREDICT;
        end
      end
      if (do_lit) begin
        x_we = wok;
        x_wdata = d_r;
        lit_nxt = d_r;
        col_nxt = col_inc[CW-1:0];
        ph_nxt = rpd_pkg::PH_AFTER;
        e_emit = 1'b1; e_col = col_r; e_ch = ch_r; e_val = d_r; e_run = 9'd1;
        if (col_inc >= {1'b0, eff_w}) begin
          col_nxt = '0;
          ph_nxt = rpd_pkg::PH_AFTER_END;
          if (ch_inc >= eff_b) begin
            e_done = 1'b1;
            row_nxt = (row_r < 16'hFFFF) ? row_r + 16'd1 : row_r;
            ch_nxt = 2'd0;
          end else begin
            ch_nxt = ch_inc[1:0];
          end
        end
      end
    end
  end

  // line store write port
  always_comb begin
    mem_we = 1'b0; mem_waddr = waddr_x; mem_wdata = x_wdata;
    if (cmd.clear_step) begin
      mem_we = 1'b1; mem_waddr = clr_addr_r; mem_wdata = 8'd0;
    end else if (cmd.run_step) begin
      mem_we = (int'(run_col_r) < MAX_ROW_PIXELS) && (int'(run_ch_r) < MAX_CHANNELS);
      mem_waddr = waddr_run; mem_wdata = lit_r;
    end else if (cmd.exec) begin
      mem_we = x_we;
    end
  end

  rpd_ram #(.Width(8), .Depth(Depth)) u_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sts.out_free      = !out_valid_r || !out_stall;
  assign sts.run_pending   = (run_n != 9'd0);
  assign sts.run_last      = (run_cnt_r == 9'd1);
  assign sts.clear_pending = fs_r;
  assign sts.clear_last    = (int'(clr_addr_r) == Depth - 1);

  assign out_valid = out_valid_r && rst_n;

  always_ff @(posedge clk) begin
    rok_r <= rok;
    if (cmd.load) begin
      d_r  <= in_data_byte;
      fs_r <= in_frame_start;
    end
    if (cmd.exec && e_emit) begin
      out_row_index   <= e_row;
      out_column      <= 10'(e_col);
      out_channel     <= e_ch;
      out_pixel_value <= e_val;
      out_run_length  <= e_run;
      out_row_done    <= e_done;
      out_status      <= e_st;
    end
    if (cmd.exec) begin
      run_cnt_r <= run_n;
      run_col_r <= col_r;
      run_ch_r  <= ch_r;
    end else if (cmd.run_step) begin
      run_cnt_r <= run_cnt_r - 9'd1;
      run_col_r <= run_col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= 11'd1; cfg_h_r <= 16'd1; cfg_b_r <= 3'd3;
      mode_r <= '0; col_r <= '0; ch_r <= '0; row_r <= '0;
      ph_r <= rpd_pkg::PH_FILTER; lit_r <= '0; left_r <= '0; hold_r <= '0;
      clr_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          rpd_pkg::CFG_WIDTH:  cfg_w_r <= cfg_data[10:0];
          rpd_pkg::CFG_HEIGHT: cfg_h_r <= cfg_data[15:0];
          rpd_pkg::CFG_BPP:    cfg_b_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (cmd.load && in_frame_start) begin
        mode_r <= '0; col_r <= '0; ch_r <= '0; row_r <= '0;
        ph_r <= rpd_pkg::PH_FILTER; lit_r <= '0; left_r <= '0; hold_r <= '0;
      end else if (cmd.exec) begin
        mode_r <= mode_nxt; col_r <= col_nxt; ch_r <= ch_nxt; row_r <= row_nxt;
        ph_r <= ph_nxt; lit_r <= lit_nxt; left_r <= left_nxt; hold_r <= hold_nxt;
      end
      if (cmd.clear_step) begin
        clr_addr_r <= sts.clear_last ? '0 : clr_addr_r + 1'b1;
      end
      if (cmd.exec && e_emit) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[design/row_predictor_rle_image_decoder.sv]
// a byte is accepted, the line store is read, then the step executes once
//   the result register is free; no new byte is taken until the byte and
//   its run fill are done; a run fill makes one line store write per cycle
// reset and every frame start clear all MAX_ROW_PIXELS*MAX_CHANNELS
//   line store entries with input stalled; config writes still taken
// ----------------------------------------------------------------------------
// row_predictor_rle_image_decoder
// Decodes row-filtered and planar run-length image bytes into pixel writes.
// ----------------------------------------------------------------------------
`default_nettype none

module row_predictor_rle_image_decoder #(
  parameter int MAX_ROW_PIXELS = rpd_pkg::MaxRowPixelsDef,
  parameter int MAX_CHANNELS   = rpd_pkg::MaxChannelsDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [rpd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [rpd_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   in_data_byte,
  input  wire logic                         in_frame_start,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [15:0]                       out_row_index,
  output logic [9:0]                        out_column,
  output logic [1:0]                        out_channel,
  output logic [7:0]                        out_pixel_value,
  output logic [8:0]                        out_run_length,
  output logic                              out_row_done,
  output logic [1:0]                        out_status
);

  rpd_pkg::cmd_t cmd;
  rpd_pkg::sts_t sts;

  rpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpd_dp #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
    .MAX_CHANNELS   (MAX_CHANNELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_data_byte    (in_data_byte),
    .in_frame_start  (in_frame_start),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_index   (out_row_index),
    .out_column      (out_column),
    .out_channel     (out_channel),
    .out_pixel_value (out_pixel_value),
    .out_run_length  (out_run_length),
    .out_row_done    (out_row_done),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

[design/rpd_checker.sv]
// ----------------------------------------------------------------------------
// rpd_checker
// Port-level checks on the decoder result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [8:0]  out_run_length,
  input wire logic        out_row_done,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_pixel_value
);

  // stalled result stays valid and keeps its pixel value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_value))
    else $error("stalled result changed");

  a_run_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_length <= 9'd256)
    else $error("run length out of range");

  a_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rpd_pkg::ST_DONE |-> out_run_length == 9'd0 && !out_row_done)
    else $error("finished image produced a write");

  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rpd_pkg::ST_UNKNOWN |-> out_row_done && out_run_length == 9'd0)
    else $error("unknown filter result malformed");

endmodule

bind row_predictor_rle_image_decoder rpd_checker u_rpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_run_length  (out_run_length),
  .out_row_done    (out_row_done),
  .out_status      (out_status),
  .out_pixel_value (out_pixel_value)
);

`default_nettype wire
